FILE: rtl/midts_pkg.sv
package midts_pkg;

  localparam int MAX_PARTICLES = 16;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
  localparam int ID_W          = 64;
  localparam int HIT_W         = 8;

  localparam logic [HIT_W-1:0] COUNT_MAX = 8'd255;

  // one table row: particle id and its hit count
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [HIT_W-1:0] cnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TRD    = 3'd1;
  localparam logic [2:0] ST_TCMP   = 3'd2;
  localparam logic [2:0] ST_ESTART = 3'd3;
  localparam logic [2:0] ST_ERD    = 3'd4;
  localparam logic [2:0] ST_ECMP   = 3'd5;

endpackage

FILE: rtl/midts_ram.sv
module midts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/majority_id_tally_sorter_top.sv
// Particle id tally and rank. Each transaction on the input side is one
// trajectory state, accepted when start is high and busy is low. States with
// in_is_measurement low are not counted. For a counted state the id table
// (one single-port-write, registered-read RAM of MAX_PARTICLES rows) is
// scanned row by row (read in ST_TRD, compared in ST_TCMP): a known id gets
// its count bumped (saturating at 255), an unknown id is appended with count
// 1, or dropped with the overflow flag set when the table is full. So a
// counted state keeps busy high until its id is found or all n rows in use
// are scanned, and not at all when the table is empty and it is not last; a
// skipped state that is not last does not raise busy at all.
// After the state flagged in_last_state the rows are emitted highest count
// first, ties in first-seen order, by repeated selection passes over the
// RAM: each pass reads all n rows (ST_ERD, then ST_ECMP for each row) and
// emits one result. An empty table gives one result with out_entry_valid
// low. Results appear for exactly one cycle, flagged by out_valid; the
// receiver cannot stall them, so there is no backpressure and every
// result must be captured when out_valid is high. out_last_entry marks the
// final result; the table and the overflow flag are cleared with it, and
// busy drops the same cycle it appears.
module majority_id_tally_sorter_top
  import midts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [ID_W-1:0]  in_particle_id,
  input  logic             in_is_measurement,
  input  logic             in_last_state,
  output logic             out_valid,
  output logic [ID_W-1:0]  out_result_id,
  output logic [HIT_W-1:0] out_hit_count,
  output logic             out_entry_valid,
  output logic             out_table_overflow,
  output logic             out_last_entry
);

  // control state
  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       used_r, used_nxt;       // rows in use
  logic                   ovf_r, ovf_nxt;         // an id was dropped
  logic [IDX_W-1:0]       idx_r, idx_nxt;         // scan pointer
  logic [CNT_W-1:0]       emitted_r, emitted_nxt; // results sent this run
  logic [MAX_PARTICLES-1:0] done_r, done_nxt;     // rows already emitted
  logic                   have_r, have_nxt;       // selection pass has a candidate
  logic                   out_valid_r, out_valid_nxt;

  // payload
  logic [ID_W-1:0]        pid_r, pid_nxt;
  logic                   last_r, last_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic [ID_W-1:0]        best_id_r, best_id_nxt;
  logic [HIT_W-1:0]       best_cnt_r, best_cnt_nxt;
  logic [ID_W-1:0]        o_id_r, o_id_nxt;
  logic [HIT_W-1:0]       o_cnt_r, o_cnt_nxt;
  logic                   o_ev_r, o_ev_nxt;
  logic                   o_ovf_r, o_ovf_nxt;
  logic                   o_last_r, o_last_nxt;

  // table RAM
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           rd_e;

  midts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PARTICLES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_e = entry_t'(ram_rdata);

  logic             at_end;    // current row is the last one in use
  logic             table_full;
  logic             take;      // current row beats the pass candidate
  logic [IDX_W-1:0] sel_idx;
  logic [ID_W-1:0]  sel_id;
  logic [HIT_W-1:0] sel_cnt;
  logic [2:0]       post_tally;

  assign at_end     = ((CNT_W'(idx_r) + CNT_W'(1)) == used_r);
  assign table_full = (used_r == CNT_W'(MAX_PARTICLES));
  // strict compare keeps the earliest row among equal counts
  assign take       = !done_r[idx_r] && (!have_r || (rd_e.cnt > best_cnt_r));
  assign sel_idx    = take ? idx_r    : best_idx_r;
  assign sel_id     = take ? rd_e.id  : best_id_r;
  assign sel_cnt    = take ? rd_e.cnt : best_cnt_r;
  assign post_tally = last_r ? ST_ESTART : ST_IDLE;

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    emitted_nxt   = emitted_r;
    done_nxt      = done_r;
    have_nxt      = have_r;
    out_valid_nxt = 1'b0;
    pid_nxt       = pid_r;
    last_nxt      = last_r;
    best_idx_nxt  = best_idx_r;
    best_id_nxt   = best_id_r;
    best_cnt_nxt  = best_cnt_r;
    o_id_nxt      = o_id_r;
    o_cnt_nxt     = o_cnt_r;
    o_ev_nxt      = o_ev_r;
    o_ovf_nxt     = o_ovf_r;
    o_last_nxt    = o_last_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = '{id: pid_r, cnt: HIT_W'(1)};
    ram_raddr     = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          pid_nxt  = in_particle_id;
          last_nxt = in_last_state;
          idx_nxt  = '0;
          if (in_is_measurement) begin
            if (used_r == '0) begin
              // empty table: append directly
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = '{id: in_particle_id, cnt: HIT_W'(1)};
              used_nxt  = CNT_W'(1);
              state_nxt = in_last_state ? ST_ESTART : ST_IDLE;
            end else begin
              state_nxt = ST_TRD;
            end
          end else if (in_last_state) begin
            state_nxt = ST_ESTART;
          end
        end
      end

      ST_TRD: begin
        state_nxt = ST_TCMP;
      end

      ST_TCMP: begin
        if (rd_e.id == pid_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r;
          ram_wdata = '{id: pid_r,
                        cnt: (rd_e.cnt == COUNT_MAX) ? rd_e.cnt : rd_e.cnt + HIT_W'(1)};
          state_nxt = post_tally;
        end else if (at_end) begin
          if (table_full) begin
            ovf_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = used_r[IDX_W-1:0];
            used_nxt  = used_r + CNT_W'(1);
          end
          state_nxt = post_tally;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_TRD;
        end
      end

      ST_ESTART: begin
        if (used_r == '0) begin
          out_valid_nxt = 1'b1;
          o_id_nxt      = '0;
          o_cnt_nxt     = '0;
          o_ev_nxt      = 1'b0;
          o_ovf_nxt     = ovf_r;
          o_last_nxt    = 1'b1;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt     = '0;
          have_nxt    = 1'b0;
          emitted_nxt = '0;
          done_nxt    = '0;
          state_nxt   = ST_ERD;
        end
      end

      ST_ERD: begin
        state_nxt = ST_ECMP;
      end

      ST_ECMP: begin
        best_idx_nxt = sel_idx;
        best_id_nxt  = sel_id;
        best_cnt_nxt = sel_cnt;
        have_nxt     = have_r || take;
        if (at_end) begin
          // pass complete: emit the winner
          out_valid_nxt     = 1'b1;
          o_id_nxt          = sel_id;
          o_cnt_nxt         = sel_cnt;
          o_ev_nxt          = 1'b1;
          o_ovf_nxt         = ovf_r;
          done_nxt[sel_idx] = 1'b1;
          emitted_nxt       = emitted_r + CNT_W'(1);
          idx_nxt           = '0;
          have_nxt          = 1'b0;
          if ((emitted_r + CNT_W'(1)) == used_r) begin
            o_last_nxt = 1'b1;
            used_nxt   = '0;
            ovf_nxt    = 1'b0;
            state_nxt  = ST_IDLE;
          end else begin
            o_last_nxt = 1'b0;
            state_nxt  = ST_ERD;
          end
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_ERD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      emitted_r   <= '0;
      done_r      <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
      emitted_r   <= emitted_nxt;
      done_r      <= done_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pid_r      <= pid_nxt;
    last_r     <= last_nxt;
    best_idx_r <= best_idx_nxt;
    best_id_r  <= best_id_nxt;
    best_cnt_r <= best_cnt_nxt;
    o_id_r     <= o_id_nxt;
    o_cnt_r    <= o_cnt_nxt;
    o_ev_r     <= o_ev_nxt;
    o_ovf_r    <= o_ovf_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_result_id      = o_id_r;
  assign out_hit_count      = o_cnt_r;
  assign out_entry_valid    = o_ev_r;
  assign out_table_overflow = o_ovf_r;
  assign out_last_entry     = o_last_r;

`ifndef SYNTHESIS
  // a result that is not the final one means the ranking run is still going
  a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_entry |-> busy)
    else $error("non-final result while idle");

  // the empty-table result is always a run of one
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_last_entry)
    else $error("invalid entry not marked last");

  // a real entry was counted at least once
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_valid |-> out_hit_count != '0)
    else $error("emitted entry with zero count");

  // row count never exceeds the table
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(MAX_PARTICLES))
    else $error("row count beyond table depth");
`endif

endmodule

FILE: bench/midts_rank_checker.sv
`timescale 1ns / 100ps

module midts_rank_checker
  import midts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [ID_W-1:0]  in_particle_id,
  input  logic             in_is_measurement,
  input  logic             in_last_state,
  input  logic             out_valid,
  input  logic [ID_W-1:0]  out_result_id,
  input  logic [HIT_W-1:0] out_hit_count,
  input  logic             out_entry_valid,
  input  logic             out_table_overflow,
  input  logic             out_last_entry,
  output int unsigned      mismatch_cnt,
  output int unsigned      ranks_pending,
  output int unsigned      ranks_checked
);

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [HIT_W-1:0] hits;
    logic             valid;
    logic             ovf;
    logic             last_e;
  } rank_t;

  // shadow of the id/count table
  logic [ID_W-1:0]  seen_id   [MAX_PARTICLES];
  logic [HIT_W-1:0] seen_hits [MAX_PARTICLES];
  int               seen_used;
  logic             dropped;
  rank_t            expected_ranks[$];
  int unsigned      fails;
  int unsigned      checked;

  task automatic tally_state(input logic [ID_W-1:0] pid);
    int k;
    for (k = 0; k < seen_used; k++) begin
      if (seen_id[k] == pid) begin
        if (seen_hits[k] != COUNT_MAX) seen_hits[k] = seen_hits[k] + 1'b1;
        return;
      end
    end
    if (seen_used < MAX_PARTICLES) begin
      seen_id[seen_used]   = pid;
      seen_hits[seen_used] = 8'd1;
      seen_used++;
    end else begin
      dropped = 1'b1;
    end
  endtask

  // highest count first; strict compare keeps first-seen order on ties
  task automatic rank_table();
    bit    taken [MAX_PARTICLES];
    int    pick;
    int    k;
    int    r;
    rank_t e;
    if (seen_used == 0) begin
      e.id     = '0;
      e.hits   = '0;
      e.valid  = 1'b0;
      e.ovf    = dropped;
      e.last_e = 1'b1;
      expected_ranks = {expected_ranks, e};
    end else begin
      for (k = 0; k < MAX_PARTICLES; k++) taken[k] = 1'b0;
      for (r = 0; r < seen_used; r++) begin
        pick = -1;
        for (k = 0; k < seen_used; k++) begin
          if (!taken[k]) begin
            if (pick < 0) pick = k;
            else if (seen_hits[k] > seen_hits[pick]) pick = k;
          end
        end
        taken[pick] = 1'b1;
        e.id     = seen_id[pick];
        e.hits   = seen_hits[pick];
        e.valid  = 1'b1;
        e.ovf    = dropped;
        e.last_e = (r == seen_used - 1);
        expected_ranks = {expected_ranks, e};
      end
    end
    seen_used = 0;
    dropped   = 1'b0;
  endtask

  task automatic check_rank();
    rank_t want;
    checked++;
    if (expected_ranks.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("%0t: unexpected ranked entry id=%h hits=%0d valid=%b ovf=%b last=%b",
                 $realtime, out_result_id, out_hit_count, out_entry_valid,
                 out_table_overflow, out_last_entry);
    end else begin
      want = expected_ranks.pop_front();
      if (out_result_id !== want.id || out_hit_count !== want.hits ||
          out_entry_valid !== want.valid || out_table_overflow !== want.ovf ||
          out_last_entry !== want.last_e) begin
        fails++;
        if (fails <= 10) begin
          $display("%0t: ranked entry wrong, expected id=%h hits=%0d valid=%b ovf=%b last=%b",
                   $realtime, want.id, want.hits, want.valid, want.ovf, want.last_e);
          $display("%0t:                        got id=%h hits=%0d valid=%b ovf=%b last=%b",
                   $realtime, out_result_id, out_hit_count, out_entry_valid,
                   out_table_overflow, out_last_entry);
        end
      end
    end
  endtask

  // results first: the last entry and the next accepted state may share an edge
  always @(posedge clk) begin
    if (!rst_n) begin
      seen_used = 0;
      dropped   = 1'b0;
      fails     = 0;
      checked   = 0;
      expected_ranks.delete();
    end else begin
      if (out_valid) check_rank();
      if (start && !busy) begin
        if (in_is_measurement) tally_state(in_particle_id);
        if (in_last_state) rank_table();
      end
    end
    mismatch_cnt  <= fails;
    ranks_checked <= checked;
    ranks_pending <= expected_ranks.size();
  end

endmodule

FILE: bench/tb_majority_id_tally_sorter_top.sv
`timescale 1ns / 100ps

module tb_majority_id_tally_sorter_top;
  import midts_pkg::*;

  // Worst case (16-row scans per state plus 16 ranking passes of 16 rows
  // per trajectory) is far below this limit, which leaves a wide margin.
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [ID_W-1:0] pid;
    logic            meas;
    logic            lst;
  } state_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [ID_W-1:0]  in_particle_id = '0;
  logic             in_is_measurement = 1'b0;
  logic             in_last_state = 1'b0;
  logic             out_valid;
  logic [ID_W-1:0]  out_result_id;
  logic [HIT_W-1:0] out_hit_count;
  logic             out_entry_valid;
  logic             out_table_overflow;
  logic             out_last_entry;

  int unsigned mismatch_cnt;
  int unsigned ranks_pending;
  int unsigned ranks_checked;

  int cycle_cnt = 0;
  int states_sent = 0;
  int tracks_sent = 0;
  int burst_left = 0;
  int steady_left = 0;

  always #4 clk = ~clk;

  majority_id_tally_sorter_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_particle_id    (in_particle_id),
    .in_is_measurement (in_is_measurement),
    .in_last_state     (in_last_state),
    .out_valid         (out_valid),
    .out_result_id     (out_result_id),
    .out_hit_count     (out_hit_count),
    .out_entry_valid   (out_entry_valid),
    .out_table_overflow(out_table_overflow),
    .out_last_entry    (out_last_entry)
  );

  // Predicts the ranked table and compares every strobed result.
  midts_rank_checker rank_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_particle_id    (in_particle_id),
    .in_is_measurement (in_is_measurement),
    .in_last_state     (in_last_state),
    .out_valid         (out_valid),
    .out_result_id     (out_result_id),
    .out_hit_count     (out_hit_count),
    .out_entry_valid   (out_entry_valid),
    .out_table_overflow(out_table_overflow),
    .out_last_entry    (out_last_entry),
    .mismatch_cnt      (mismatch_cnt),
    .ranks_pending     (ranks_pending),
    .ranks_checked     (ranks_checked)
  );

  // Watchdog: a hung block or lost results end the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d ranked entries still expected",
               cycle_cnt, ranks_pending);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [ID_W-1:0] rand_id();
    return {$urandom, $urandom};
  endfunction

  // Present one state and hold it until the transaction completes. Called
  // right after a rising edge; returns right after the accepting edge, so
  // the caller may present the next state back to back in the same step.
  task automatic send_state(input logic [ID_W-1:0] pid, input logic meas,
                            input logic lst);
    start             <= 1'b1;
    in_particle_id    <= pid;
    in_is_measurement <= meas;
    in_last_state     <= lst;
    do @(posedge clk); while (busy);
    states_sent++;
    if (lst) tracks_sent++;
  endtask

  // Sender pacing: bursts of 1..8 transactions, then a random gap that may be empty.
  // Either drops start and moves time, or touches nothing at all.
  task automatic pace();
    int gap;
    if (steady_left > 0) begin
      steady_left--;
      return;
    end
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 7);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every ranked entry predicted so far has come out.
  // The first edge lets the checker's pending count catch up.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (ranks_pending != 0);
  endtask

  // One trajectory of len states drawn from a pool of pool_sz ids. bias is
  // the percentage of draws forced onto the first pool id (for heavy
  // repeats); a few states bring a fresh random id, a few are skipped.
  task automatic random_trajectory(input int len, input int pool_sz, input int bias);
    logic [ID_W-1:0] pool [24];
    logic [ID_W-1:0] pid;
    int              k;
    for (k = 0; k < pool_sz; k++) pool[k] = rand_id();
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < bias) pid = pool[0];
      else if ($urandom_range(0, 15) == 0) pid = rand_id();
      else pid = pool[$urandom_range(0, pool_sz - 1)];
      send_state(pid, $urandom_range(0, 15) != 0, k == len - 1);
      pace();
    end
  endtask

  initial begin
    state_t directed_q[$];
    state_t s;
    int     k;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // empty table at the end: a skipped state marked last
    s.pid = {ID_W{1'b1}}; s.meas = 1'b0; s.lst = 1'b1; directed_q = {directed_q, s};
    // single entry, id zero
    s.pid = '0;           s.meas = 1'b1; s.lst = 1'b1; directed_q = {directed_q, s};
    // equal counts keep first-seen order; skipped state in between
    s.pid = 64'h0000_0000_0000_00b0; s.meas = 1'b1; s.lst = 1'b0;
    directed_q = {directed_q, s};
    s.pid = 64'h8000_0000_0000_00a0; s.meas = 1'b1; s.lst = 1'b0;
    directed_q = {directed_q, s};
    s.pid = 64'h8000_0000_0000_00a0; s.meas = 1'b0; s.lst = 1'b0;
    directed_q = {directed_q, s};
    s.pid = 64'h8000_0000_0000_00a0; s.meas = 1'b1; s.lst = 1'b0;
    directed_q = {directed_q, s};
    s.pid = 64'h0000_0000_0000_00b0; s.meas = 1'b1; s.lst = 1'b1;
    directed_q = {directed_q, s};
    // table overflow: 17 distinct ids, the 17th is dropped; a known id
    // still counts afterwards and the flag rides on every entry
    for (k = 0; k < 17; k++) begin
      s.pid = {ID_W{1'b1}} >> k; s.meas = 1'b1; s.lst = 1'b0;
      directed_q = {directed_q, s};
    end
    s.pid = {ID_W{1'b1}}; s.meas = 1'b1; s.lst = 1'b1; directed_q = {directed_q, s};

    foreach (directed_q[i]) begin
      send_state(directed_q[i].pid, directed_q[i].meas, directed_q[i].lst);
      pace();
    end
    drain();

    // --- random part ---
    // a stretch with no sender gaps at all
    steady_left = 30;
    while (states_sent < 150) begin
      if ($urandom_range(0, 5) == 0)
        random_trajectory($urandom_range(20, 40), $urandom_range(17, 22), 0);
      else
        random_trajectory($urandom_range(1, 14), $urandom_range(1, 6), 0);
    end

    // sender waits out the whole ranking before the next trajectory
    drain();

    // long trajectory dominated by one id: drives its count into saturation at 255
    random_trajectory(300, 3, 94);

    while (states_sent < 470) begin
      if ($urandom_range(0, 5) == 0)
        random_trajectory($urandom_range(20, 40), $urandom_range(17, 22), 0);
      else
        random_trajectory($urandom_range(1, 14), $urandom_range(1, 6), 0);
    end

    // --- wind-down ---
    drain();
    repeat (20) @(posedge clk);

    $display("Ran %0d trajectory states over %0d trajectories; %0d ranked entries checked.",
             states_sent, tracks_sent, ranks_checked);
    $display("Included empty tables, count ties, id-table overflow and count saturation.");
    if (mismatch_cnt == 0 && ranks_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
